/* rtl/wdwr_pkg.sv */
package wdwr_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int WEIGHT_BITS = 16;

    localparam int KEY_W  = 16;
    localparam int WIN_W  = 16;
    localparam int SUM_W  = 22;
    localparam int DCNT_W = 7;
    localparam int IDX_W  = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    // running sum over a whole walk never overflows this width
    localparam int RUN_W  = (SUM_W > WIN_W + CNT_W) ? SUM_W : WIN_W + CNT_W;
    localparam int CMPC_W = (CNT_W > DCNT_W) ? CNT_W : DCNT_W;

    localparam logic [WIN_W-1:0] WEIGHT_MASK =
        (WEIGHT_BITS >= WIN_W) ? {WIN_W{1'b1}} : WIN_W'((64'd1 << WEIGHT_BITS) - 64'd1);

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_LOAD  = 2'd1;
    localparam logic [1:0] KIND_BEGIN = 2'd2;
    localparam logic [1:0] KIND_DRAW  = 2'd3;

    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_SHORT     = 3'd1;
    localparam logic [2:0] STAT_BAD_PICK  = 3'd2;
    localparam logic [2:0] STAT_NO_DRAWS  = 3'd3;
    localparam logic [2:0] STAT_FULL      = 3'd4;

endpackage

/* rtl/weighted_draw_without_replacement.sv */
// Weighted draw without replacement over a table of up to MAX_ENTRIES keyed weights, held in
// two single-port synchronous memories (key and weight). Clear, load and begin items present
// their result in the cycle after they are accepted. A draw item walks the loaded entries in
// load order, one memory read per cycle, accumulating the weights of entries still in the
// pool, and ends early at the chosen entry. Draws rejected up front (no draws left, pick of
// zero or above the pool weight) also present their result in the cycle after acceptance.
// One item is in work at a time; a new item is accepted once the block is idle and the result
// register is empty or being emptied.
module weighted_draw_without_replacement
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic [1:0]                    kind,
    input  logic [wdwr_pkg::KEY_W-1:0]    entry_key,
    input  logic [wdwr_pkg::WIN_W-1:0]    entry_weight,
    input  logic [wdwr_pkg::DCNT_W-1:0]   draw_count,
    input  logic [wdwr_pkg::SUM_W-1:0]    pick,

    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic [2:0]                    status,
    output logic [wdwr_pkg::KEY_W-1:0]    chosen_key,
    output logic [wdwr_pkg::SUM_W-1:0]    remaining_weight
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_WALK = 1'b1;

    localparam int MAX_ENTRIES = wdwr_pkg::MAX_ENTRIES;
    localparam int KEY_W  = wdwr_pkg::KEY_W;
    localparam int WIN_W  = wdwr_pkg::WIN_W;
    localparam int SUM_W  = wdwr_pkg::SUM_W;
    localparam int IDX_W  = wdwr_pkg::IDX_W;
    localparam int CNT_W  = wdwr_pkg::CNT_W;
    localparam int RUN_W  = wdwr_pkg::RUN_W;
    localparam int CMPC_W = wdwr_pkg::CMPC_W;

    logic [KEY_W-1:0] key_mem [MAX_ENTRIES];
    logic [WIN_W-1:0] wt_mem  [MAX_ENTRIES];

    logic                   state_reg, state_next;
    logic [MAX_ENTRIES-1:0] taken_reg, taken_next;
    logic [CNT_W-1:0]       entry_count_reg, entry_count_next;
    logic [SUM_W-1:0]       total_weight_reg, total_weight_next;
    logic [SUM_W-1:0]       pool_weight_reg, pool_weight_next;
    logic [CNT_W-1:0]       draws_left_reg, draws_left_next;

    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic                   rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]       rd_idx_reg, rd_idx_next;
    logic [RUN_W-1:0]       run_reg, run_next;
    logic [SUM_W-1:0]       pick_reg, pick_next;
    logic [KEY_W-1:0]       rd_key_reg;
    logic [WIN_W-1:0]       rd_wt_reg;

    logic                   rsp_valid_reg, rsp_valid_next;
    logic [2:0]             status_reg, status_next;
    logic [KEY_W-1:0]       chosen_key_reg, chosen_key_next;
    logic [SUM_W-1:0]       remaining_reg, remaining_next;

    logic                   accept;
    logic                   issue;
    logic [IDX_W-1:0]       rd_addr;
    logic                   live;
    logic [RUN_W-1:0]       run_sum;
    logic                   hit;
    logic                   wr_en;
    logic [WIN_W-1:0]       wt_in;
    logic [SUM_W:0]         total_sum;
    logic [SUM_W-1:0]       wt_ext;

    assign req_ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign accept    = req_valid && req_ready;

    assign wt_in   = entry_weight & wdwr_pkg::WEIGHT_MASK;
    assign wr_en   = accept && (kind == wdwr_pkg::KIND_LOAD)
                     && (entry_count_reg < CNT_W'(MAX_ENTRIES));
    assign total_sum = {1'b0, total_weight_reg} + (SUM_W + 1)'(wt_in);

    // walk: issue a read at idx_reg, judge the entry read in the previous cycle
    assign issue   = (state_reg == S_WALK) && (idx_reg < entry_count_reg);
    assign rd_addr = idx_reg[IDX_W-1:0];
    assign live    = rd_vld_reg && !taken_reg[rd_idx_reg];
    assign run_sum = run_reg + RUN_W'(rd_wt_reg);
    assign hit     = live && (RUN_W'(pick_reg) <= run_sum);
    assign wt_ext  = SUM_W'(rd_wt_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[entry_count_reg[IDX_W-1:0]] <= entry_key;
            wt_mem[entry_count_reg[IDX_W-1:0]]  <= wt_in;
        end
        if (issue)
        begin
            rd_key_reg <= key_mem[rd_addr];
            rd_wt_reg  <= wt_mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        taken_next        = taken_reg;
        entry_count_next  = entry_count_reg;
        total_weight_next = total_weight_reg;
        pool_weight_next  = pool_weight_reg;
        draws_left_next   = draws_left_reg;
        idx_next          = idx_reg;
        rd_vld_next       = 1'b0;
        rd_idx_next       = rd_idx_reg;
        run_next          = run_reg;
        pick_next         = pick_reg;
        rsp_valid_next    = rsp_valid_reg && !rsp_ready;
        status_next       = status_reg;
        chosen_key_next   = chosen_key_reg;
        remaining_next    = remaining_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next     = wdwr_pkg::STAT_OK;
                    chosen_key_next = '0;
                    rsp_valid_next  = 1'b1;
                    case (kind)
                        wdwr_pkg::KIND_CLEAR:
                        begin
                            taken_next        = '0;
                            entry_count_next  = '0;
                            total_weight_next = '0;
                            pool_weight_next  = '0;
                            draws_left_next   = '0;
                        end
                        wdwr_pkg::KIND_LOAD:
                        begin
                            if (wr_en)
                            begin
                                // out of the pool until the next begin that is not rejected as short
                                taken_next[entry_count_reg[IDX_W-1:0]] = 1'b1;
                                entry_count_next  = entry_count_reg + CNT_W'(1);
                                total_weight_next = total_sum[SUM_W] ? wdwr_pkg::SUM_MAX
                                                                     : total_sum[SUM_W-1:0];
                            end
                            else
                            begin
                                status_next = wdwr_pkg::STAT_FULL;
                            end
                        end
                        wdwr_pkg::KIND_BEGIN:
                        begin
                            if (CMPC_W'(draw_count) > CMPC_W'(entry_count_reg))
                            begin
                                draws_left_next = '0;
                                status_next     = wdwr_pkg::STAT_SHORT;
                            end
                            else
                            begin
                                taken_next       = '0;
                                pool_weight_next = total_weight_reg;
                                draws_left_next  = CNT_W'(draw_count);
                            end
                        end
                        default:
                        begin
                            if (draws_left_reg == '0)
                            begin
                                status_next = wdwr_pkg::STAT_NO_DRAWS;
                            end
                            else if ((pick == '0) || (pick > pool_weight_reg))
                            begin
                                status_next = wdwr_pkg::STAT_BAD_PICK;
                            end
                            else
                            begin
                                // hold the result until the walk ends
                                rsp_valid_next = 1'b0;
                                state_next     = S_WALK;
                                idx_next       = '0;
                                run_next       = '0;
                                pick_next      = pick;
                            end
                        end
                    endcase
                    remaining_next = pool_weight_next;
                end
            end
            S_WALK:
            begin
                if (issue)
                begin
                    idx_next    = idx_reg + CNT_W'(1);
                    rd_idx_next = rd_addr;
                end
                rd_vld_next = issue && !hit;
                if (live)
                begin
                    run_next = run_sum;
                end
                if (hit)
                begin
                    taken_next[rd_idx_reg] = 1'b1;
                    pool_weight_next = (wt_ext > pool_weight_reg) ? '0
                                                                  : pool_weight_reg - wt_ext;
                    draws_left_next  = draws_left_reg - CNT_W'(1);
                    status_next      = wdwr_pkg::STAT_OK;
                    chosen_key_next  = rd_key_reg;
                    remaining_next   = pool_weight_next;
                    rsp_valid_next   = 1'b1;
                    state_next       = S_IDLE;
                end
                else if (!issue && !rd_vld_reg)
                begin
                    // walk ran off the end: only possible after saturation
                    status_next     = wdwr_pkg::STAT_BAD_PICK;
                    chosen_key_next = '0;
                    remaining_next  = pool_weight_reg;
                    rsp_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            taken_reg        <= '0;
            entry_count_reg  <= '0;
            total_weight_reg <= '0;
            pool_weight_reg  <= '0;
            draws_left_reg   <= '0;
            idx_reg          <= '0;
            rd_vld_reg       <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            taken_reg        <= taken_next;
            entry_count_reg  <= entry_count_next;
            total_weight_reg <= total_weight_next;
            pool_weight_reg  <= pool_weight_next;
            draws_left_reg   <= draws_left_next;
            idx_reg          <= idx_next;
            rd_vld_reg       <= rd_vld_next;
            rsp_valid_reg    <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg     <= rd_idx_next;
        run_reg        <= run_next;
        pick_reg       <= pick_next;
        status_reg     <= status_next;
        chosen_key_reg <= chosen_key_next;
        remaining_reg  <= remaining_next;
    end

    assign rsp_valid        = rsp_valid_reg;
    assign status           = status_reg;
    assign chosen_key       = chosen_key_reg;
    assign remaining_weight = remaining_reg;

    a_draws_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        draws_left_reg <= entry_count_reg)
        else $error("more draws armed than entries loaded");

    a_pool_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pool_weight_reg <= total_weight_reg)
        else $error("pool weight exceeds total weight");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond table size");

    a_walk_slot_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> !rsp_valid_reg)
        else $error("result pending during a walk");

    a_hit_uses_draw: assert property (@(posedge clk) disable iff (!rst_n)
        hit |=> (draws_left_reg == $past(draws_left_reg) - CNT_W'(1)) && rsp_valid_reg)
        else $error("chosen entry did not use up a draw");

endmodule
